/* rtl/core/embedding_grad_scatter_addresser_core_defines.svh */
// assertion macros for the embedding gradient scatter addresser core
`ifndef EMBEDDING_GRAD_SCATTER_ADDRESSER_CORE_DEFINES_SVH
`define EMBEDDING_GRAD_SCATTER_ADDRESSER_CORE_DEFINES_SVH

// same-cycle implication on the core clock
`define EGSA_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("egsa assertion failed");

// next-cycle implication on the core clock
`define EGSA_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("egsa assertion failed");

`endif

/* rtl/core/egsa_pkg.sv */
// shared constants and types for the embedding gradient scatter addresser
`default_nettype none

package egsa_pkg;

   localparam int MAX_ROWS_DEFAULT = 16;

   localparam int TOKEN_W     = 31;
   localparam int BATCH_W     = 5;
   localparam int ROWS_W      = 15;
   localparam int ADDR_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int COLL_W      = 4;
   localparam int VOPS_W      = 20;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_SELECTED     = 2'd0,
      STATUS_OTHER_TILE   = 2'd1,
      STATUS_OUT_OF_VOCAB = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BATCH_ROWS    = 3'd0,
      CSR_VOCAB_SIZE    = 3'd1,
      CSR_TILE_START    = 3'd2,
      CSR_TILE_ROWS     = 3'd3,
      CSR_HIDDEN_WIDTH  = 3'd4,
      CSR_TABLE_BASE    = 3'd5,
      CSR_GRADIENT_BASE = 3'd6
   } csr_index_type;

   typedef struct packed {
      status_type status;
      logic       duplicate;
      logic       last;
      logic       no_updates;
   } item_flags_type;

endpackage

`default_nettype wire

/* rtl/core/egsa_seen_cell.sv */
// one cell of the seen-token chain: holds a token, compares, hands it on
`default_nettype none

module egsa_seen_cell #(
   parameter int ROW_W = 5,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  logic                         shift,
   input  logic [egsa_pkg::TOKEN_W-1:0] din,
   input  logic [egsa_pkg::TOKEN_W-1:0] probe,
   input  logic [ROW_W-1:0]             count,
   output logic [egsa_pkg::TOKEN_W-1:0] dout,
   output logic                         hit
);
   import egsa_pkg::*;

   logic [TOKEN_W-1:0] token_ff;
   logic [TOKEN_W-1:0] token_in;

   assign token_in = shift ? din : token_ff;

   always_ff @(posedge clock) begin
      token_ff <= token_in;
   end

   assign dout = token_ff;
   assign hit  = (count > ROW_W'(INDEX)) && (token_ff == probe);

endmodule

`default_nettype wire

/* rtl/core/egsa_result_stage.sv */
// result register: row addresses, vector-op total and counts of one transaction
`default_nettype none

module egsa_result_stage #(
   parameter int ROW_W = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  egsa_pkg::item_flags_type       in_flags,
   input  logic [egsa_pkg::ROWS_W-1:0]    in_local,
   input  logic [ROW_W-1:0]               in_len,
   input  logic [ROW_W-1:0]               in_selected,
   input  logic [ROW_W-1:0]               in_unique,
   input  logic [egsa_pkg::ROWS_W-1:0]    hidden_width,
   input  logic [egsa_pkg::ADDR_W-1:0]    table_base,
   input  logic [egsa_pkg::ADDR_W-1:0]    gradient_base,
   output logic                           rsp_valid,
   output logic [egsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_duplicate,
   output logic [egsa_pkg::ADDR_W-1:0]    rsp_source_address,
   output logic [egsa_pkg::ADDR_W-1:0]    rsp_target_address,
   output logic                           rsp_last,
   output logic [egsa_pkg::COUNT_W-1:0]   rsp_selected_count,
   output logic [egsa_pkg::COUNT_W-1:0]   rsp_unique_count,
   output logic [egsa_pkg::COLL_W-1:0]    rsp_collision_count,
   output logic                           rsp_no_updates,
   output logic [egsa_pkg::VOPS_W-1:0]    rsp_vector_ops
);
   import egsa_pkg::*;

   logic [2*ROWS_W-1:0]     row_prod;
   logic [ROW_W+ROWS_W-1:0] ops_prod;
   logic                    is_selected;
   logic [ADDR_W-1:0]       src_addr;
   logic [ADDR_W-1:0]       dst_addr;
   logic [VOPS_W-1:0]       vops;

   logic                    valid_ff,      valid_in;
   logic [STATUS_W-1:0]     status_ff,     status_in;
   logic                    dup_ff,        dup_in;
   logic [ADDR_W-1:0]       src_ff,        src_in;
   logic [ADDR_W-1:0]       dst_ff,        dst_in;
   logic                    last_ff,       last_in;
   logic [COUNT_W-1:0]      sel_cnt_ff,    sel_cnt_in;
   logic [COUNT_W-1:0]      uniq_cnt_ff,   uniq_cnt_in;
   logic [COLL_W-1:0]       coll_ff,       coll_in;
   logic                    no_upd_ff,     no_upd_in;
   logic [VOPS_W-1:0]       vops_ff,       vops_in;

   assign is_selected = (in_flags.status == STATUS_SELECTED);
   assign row_prod    = (2*ROWS_W)'(in_local) * (2*ROWS_W)'(hidden_width);
   assign ops_prod    = (ROW_W+ROWS_W)'(in_selected) * (ROW_W+ROWS_W)'(hidden_width);

   assign src_addr = table_base + {row_prod[ADDR_W-2:0], 1'b0};
   assign dst_addr = gradient_base + {row_prod[ADDR_W-3:0], 2'b00};
   assign vops     = VOPS_W'(in_len) + VOPS_W'({ops_prod, 1'b0});

   always_comb begin
      valid_in    = advance ? in_valid : valid_ff;
      status_in   = in_flags.status;
      dup_in      = in_flags.duplicate;
      src_in      = is_selected ? src_addr : '0;
      dst_in      = is_selected ? dst_addr : '0;
      last_in     = in_flags.last;
      sel_cnt_in  = COUNT_W'(in_selected);
      uniq_cnt_in = COUNT_W'(in_unique);
      coll_in     = COLL_W'(in_selected - in_unique);
      no_upd_in   = in_flags.no_updates;
      vops_in     = in_flags.last ? vops : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         status_ff   <= status_in;
         dup_ff      <= dup_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         last_ff     <= last_in;
         sel_cnt_ff  <= sel_cnt_in;
         uniq_cnt_ff <= uniq_cnt_in;
         coll_ff     <= coll_in;
         no_upd_ff   <= no_upd_in;
         vops_ff     <= vops_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_duplicate       = dup_ff;
   assign rsp_source_address  = src_ff;
   assign rsp_target_address  = dst_ff;
   assign rsp_last            = last_ff;
   assign rsp_selected_count  = sel_cnt_ff;
   assign rsp_unique_count    = uniq_cnt_ff;
   assign rsp_collision_count = coll_ff;
   assign rsp_no_updates      = no_upd_ff;
   assign rsp_vector_ops      = vops_ff;

endmodule

`default_nettype wire

/* rtl/core/embedding_grad_scatter_addresser_core.sv */
// top level of the embedding gradient scatter addresser
// Takes one token index per clock while req_stall is low and returns one result per
// token via the first-stage and result registers. The accepting cycle classifies the
// token against the vocabulary and tile window and probes the chain of MAX_ROWS
// seen-token cells in parallel, so batch counts and the duplicate flag are final before
// the next token arrives; the following stage multiplies the local row by the hidden
// width into the result register. Sustained rate is one transaction per clock while
// rsp_stall is low. Registers are to be written only while no transaction is in flight.
`default_nettype none
`include "embedding_grad_scatter_addresser_core_defines.svh"

module embedding_grad_scatter_addresser_core #(
   parameter int MAX_ROWS = egsa_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [egsa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [egsa_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [egsa_pkg::TOKEN_W-1:0]      req_token,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [egsa_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_duplicate,
   output logic [egsa_pkg::ADDR_W-1:0]       rsp_source_address,
   output logic [egsa_pkg::ADDR_W-1:0]       rsp_target_address,
   output logic                              rsp_last,
   output logic [egsa_pkg::COUNT_W-1:0]      rsp_selected_count,
   output logic [egsa_pkg::COUNT_W-1:0]      rsp_unique_count,
   output logic [egsa_pkg::COLL_W-1:0]       rsp_collision_count,
   output logic                              rsp_no_updates,
   output logic [egsa_pkg::VOPS_W-1:0]       rsp_vector_ops
);
   import egsa_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS + 1);
   localparam int LEN_W = (ROW_W > BATCH_W) ? ROW_W : BATCH_W;

   // configuration registers
   logic [BATCH_W-1:0] batch_rows_ff,    batch_rows_in;
   logic [TOKEN_W-1:0] vocab_size_ff,    vocab_size_in;
   logic [TOKEN_W-1:0] tile_start_ff,    tile_start_in;
   logic [ROWS_W-1:0]  tile_rows_ff,     tile_rows_in;
   logic [ROWS_W-1:0]  hidden_width_ff,  hidden_width_in;
   logic [ADDR_W-1:0]  table_base_ff,    table_base_in;
   logic [ADDR_W-1:0]  gradient_base_ff, gradient_base_in;

   // batch state
   logic [ROW_W-1:0]   pos_ff,  pos_in;
   logic [ROW_W-1:0]   sel_ff,  sel_in;
   logic [ROW_W-1:0]   uniq_ff, uniq_in;

   // first stage
   logic               s1_valid_ff, s1_valid_in;
   item_flags_type     s1_flags_ff, s1_flags_in;
   logic [ROWS_W-1:0]  s1_local_ff;
   logic [ROW_W-1:0]   s1_len_ff;
   logic [ROW_W-1:0]   s1_sel_ff;
   logic [ROW_W-1:0]   s1_uniq_ff;

   logic               accept;
   logic               out_free;
   logic [LEN_W-1:0]   rows_ext;
   logic [ROW_W-1:0]   batch_len;
   logic [ROW_W:0]     pos_plus;
   logic               last_now;
   logic               in_vocab;
   logic [TOKEN_W-1:0] offset;
   logic               selected;
   logic               seen_hit;
   logic               insert;
   logic [ROW_W-1:0]   sel_next;
   logic [ROW_W-1:0]   uniq_next;

   logic [TOKEN_W-1:0] chain_token [MAX_ROWS+1];
   logic [MAX_ROWS-1:0] cell_hit;

   // configuration port
   always_comb begin
      batch_rows_in    = batch_rows_ff;
      vocab_size_in    = vocab_size_ff;
      tile_start_in    = tile_start_ff;
      tile_rows_in     = tile_rows_ff;
      hidden_width_in  = hidden_width_ff;
      table_base_in    = table_base_ff;
      gradient_base_in = gradient_base_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BATCH_ROWS:    batch_rows_in    = csr_write_data[BATCH_W-1:0];
            CSR_VOCAB_SIZE:    vocab_size_in    = csr_write_data[TOKEN_W-1:0];
            CSR_TILE_START:    tile_start_in    = csr_write_data[TOKEN_W-1:0];
            CSR_TILE_ROWS:     tile_rows_in     = csr_write_data[ROWS_W-1:0];
            CSR_HIDDEN_WIDTH:  hidden_width_in  = csr_write_data[ROWS_W-1:0];
            CSR_TABLE_BASE:    table_base_in    = csr_write_data[ADDR_W-1:0];
            CSR_GRADIENT_BASE: gradient_base_in = csr_write_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_rows_ff    <= BATCH_W'(1);
         vocab_size_ff    <= TOKEN_W'(1);
         tile_start_ff    <= '0;
         tile_rows_ff     <= ROWS_W'(1);
         hidden_width_ff  <= ROWS_W'(1);
         table_base_ff    <= '0;
         gradient_base_ff <= '0;
      end else begin
         batch_rows_ff    <= batch_rows_in;
         vocab_size_ff    <= vocab_size_in;
         tile_start_ff    <= tile_start_in;
         tile_rows_ff     <= tile_rows_in;
         hidden_width_ff  <= hidden_width_in;
         table_base_ff    <= table_base_in;
         gradient_base_ff <= gradient_base_in;
      end
   end

   // handshake
   assign out_free  = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // batch length, clamped
   assign rows_ext  = LEN_W'(batch_rows_ff);
   assign batch_len = (rows_ext == '0)               ? ROW_W'(1) :
                      (rows_ext > LEN_W'(MAX_ROWS))  ? ROW_W'(MAX_ROWS) :
                                                       ROW_W'(rows_ext);
   assign pos_plus  = {1'b0, pos_ff} + (ROW_W+1)'(1);
   assign last_now  = (pos_plus >= {1'b0, batch_len});

   // classification
   assign in_vocab = (req_token < vocab_size_ff);
   assign offset   = req_token - tile_start_ff;
   assign selected = in_vocab && (req_token >= tile_start_ff)
                     && (offset < TOKEN_W'(tile_rows_ff));

   // seen-token chain
   assign chain_token[0] = req_token;

   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
      egsa_seen_cell #(
         .ROW_W (ROW_W),
         .INDEX (i)
      ) u_cell (
         .clock (clock),
         .shift (insert),
         .din   (chain_token[i]),
         .probe (req_token),
         .count (uniq_ff),
         .dout  (chain_token[i+1]),
         .hit   (cell_hit[i])
      );
   end

   assign seen_hit  = |cell_hit;
   assign insert    = accept && selected && !seen_hit && (uniq_ff < ROW_W'(MAX_ROWS));
   assign sel_next  = (selected && (sel_ff < ROW_W'(MAX_ROWS))) ? sel_ff + ROW_W'(1) : sel_ff;
   assign uniq_next = (selected && !seen_hit && (uniq_ff < ROW_W'(MAX_ROWS)))
                      ? uniq_ff + ROW_W'(1) : uniq_ff;

   always_comb begin
      pos_in  = pos_ff;
      sel_in  = sel_ff;
      uniq_in = uniq_ff;
      if (accept) begin
         if (last_now) begin
            pos_in  = '0;
            sel_in  = '0;
            uniq_in = '0;
         end else begin
            pos_in  = pos_plus[ROW_W-1:0];
            sel_in  = sel_next;
            uniq_in = uniq_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sel_ff  <= '0;
         uniq_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         sel_ff  <= sel_in;
         uniq_ff <= uniq_in;
      end
   end

   // first stage register
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
      if (!in_vocab) begin
         s1_flags_in.status = STATUS_OUT_OF_VOCAB;
      end else if (!selected) begin
         s1_flags_in.status = STATUS_OTHER_TILE;
      end else begin
         s1_flags_in.status = STATUS_SELECTED;
      end
      s1_flags_in.duplicate  = selected && seen_hit;
      s1_flags_in.last       = last_now;
      s1_flags_in.no_updates = last_now && (sel_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= s1_flags_in;
         s1_local_ff <= offset[ROWS_W-1:0];
         s1_len_ff   <= batch_len;
         s1_sel_ff   <= sel_next;
         s1_uniq_ff  <= uniq_next;
      end
   end

   egsa_result_stage #(
      .ROW_W (ROW_W)
   ) u_result (
      .clock               (clock),
      .reset               (reset),
      .advance             (out_free),
      .in_valid            (s1_valid_ff),
      .in_flags            (s1_flags_ff),
      .in_local            (s1_local_ff),
      .in_len              (s1_len_ff),
      .in_selected         (s1_sel_ff),
      .in_unique           (s1_uniq_ff),
      .hidden_width        (hidden_width_ff),
      .table_base          (table_base_ff),
      .gradient_base       (gradient_base_ff),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_duplicate       (rsp_duplicate),
      .rsp_source_address  (rsp_source_address),
      .rsp_target_address  (rsp_target_address),
      .rsp_last            (rsp_last),
      .rsp_selected_count  (rsp_selected_count),
      .rsp_unique_count    (rsp_unique_count),
      .rsp_collision_count (rsp_collision_count),
      .rsp_no_updates      (rsp_no_updates),
      .rsp_vector_ops      (rsp_vector_ops)
   );

   // checks
   `EGSA_ASSERT_SAME(a_unique_within_selected, 1'b1, uniq_ff <= sel_ff)
   `EGSA_ASSERT_NEXT(a_last_restarts_batch, accept && last_now, (pos_ff == '0) && (sel_ff == '0) && (uniq_ff == '0))
   `EGSA_ASSERT_SAME(a_unselected_plain, rsp_valid && (rsp_status != STATUS_SELECTED), !rsp_duplicate && (rsp_source_address == '0) && (rsp_target_address == '0))
   `EGSA_ASSERT_SAME(a_totals_on_last_only, rsp_valid && !rsp_last, (rsp_vector_ops == '0) && !rsp_no_updates)

endmodule

`default_nettype wire
